/* hw/rtl/lisp_pkg.sv */
// ============================================================================
// lisp_pkg: shared definitions of the linear interpolation stream player
// Request codes, result status codes, register indexes and fixed field widths.
// ============================================================================
package lisp_pkg;

    localparam int ACTION_W    = 3;
    localparam int LOAD_ADDR_W = 13;
    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 6;
    localparam int FC_W        = 13;
    localparam int CHAN_W      = 2;
    localparam int STEP_W      = 24;
    localparam int STATUS_W    = 2;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;
    // A frame index times a stride of at most three, plus one, fits in 15 bits.
    localparam int RADDR_W     = 15;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

    localparam logic [ACTION_W-1:0] ACT_LOAD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PLAY    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REWIND  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PRODUCE = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_STREAM   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_PLAYING = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_CHANNELS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_CHANNELS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP            = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

/* hw/rtl/lisp_store.sv */
// ============================================================================
// lisp_store: sample store
// Simple dual-port sample memory with one write and one registered read per cycle.
// Reads beyond the store return zero, and writes beyond it are dropped.
// ============================================================================
module lisp_store
    import lisp_pkg::*;
#(
    parameter int STORE_WORDS = 8192
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [LOAD_ADDR_W-1:0] wr_addr,
    input  sample_t                wr_data,
    input  logic [RADDR_W-1:0]     rd_addr,
    output sample_t                rd_data
);

    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    sample_t mem [STORE_WORDS];
    sample_t rd_word_reg;
    logic    rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && (32'(wr_addr) < STORE_WORDS)) begin
            mem[AW'(wr_addr)] <= wr_data;
        end
        rd_word_reg <= mem[AW'(rd_addr)];
        rd_ok_reg   <= (32'(rd_addr) < STORE_WORDS);
    end

    assign rd_data = rd_ok_reg ? rd_word_reg : '0;

endmodule

/* hw/rtl/lisp_lerp.sv */
// ============================================================================
// lisp_lerp: shared interpolation unit
// Two-stage unit computing a + floor((b - a) * f / 2^FRAC_BITS).
// The first stage multiplies, the second adds; each stage holds until reloaded.
// ============================================================================
module lisp_lerp
    import lisp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  sample_t              a,
    input  sample_t              b,
    input  logic [FRAC_BITS-1:0] f,
    output logic                 out_valid,
    output sample_t              result
);

    localparam int DW = SAMPLE_W + 1;
    localparam int PW = DW + FRAC_BITS + 1;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_reg;
    sample_t              a_reg;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    sample_t              result_reg;
    logic signed [DW-1:0] shifted;
    logic signed [DW-1:0] sum;

    assign diff = DW'(b) - DW'(a);
    assign prod = PW'(diff) * $signed({1'b0, f});

    assign shifted = prod_reg[FRAC_BITS +: DW];
    assign sum     = DW'(a_reg) + shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
        if (in_valid) begin
            prod_reg <= prod;
            a_reg    <= a;
        end
        if (s1_valid_reg) begin
            result_reg <= sum[SAMPLE_W-1:0];
        end
    end

    assign out_valid = s2_valid_reg;
    assign result    = result_reg;

endmodule

/* hw/rtl/linear_interp_stream_player.sv */
// ============================================================================
// linear_interp_stream_player: linear interpolation stream player
// Plays interleaved mono or stereo Q1.15 frames from a sample store at a
// fixed-point step, blending neighboring frames with one shared multiplier.
// ============================================================================
//
//  Channel  Direction  Moves
//  s_       in         requests: load, play, stop, rewind, produce
//  m_       out        results: one per request, up to MAX_BURST per produce
//  cfg_     in         register writes, no read-back
//
//  Every request but a produce that plays frames yields its result in the cycle
//  after acceptance. A produced frame takes four reads through the single store
//  read port, then two passes through the two-stage multiply-add unit.
//  A stalled m_ channel holds the sequencer before each frame is written out.
//  Reset restores control state and config defaults, but not the sample store.
//
module linear_interp_stream_player
    import lisp_pkg::*;
#(
    parameter int STORE_WORDS = 8192,
    parameter int MAX_BURST   = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // load_address [12:0], sample [28:13], count [34:29], zero fill [39:35]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action [2:0]
    input  logic [ACTION_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left [15:0], right [31:16], frame_index [44:32], playing [45], zero [47:46]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PW = FC_W + FRAC_BITS;
    localparam int SW = STEP_W + FRAC_BITS;
    localparam int BW = (MAX_BURST > 1) ? $clog2(MAX_BURST + 1) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD_A0  = 4'd1;
    localparam logic [3:0] ST_RD_B0  = 4'd2;
    localparam logic [3:0] ST_RD_A1  = 4'd3;
    localparam logic [3:0] ST_RD_B1  = 4'd4;
    localparam logic [3:0] ST_LERP_L = 4'd5;
    localparam logic [3:0] ST_LERP_R = 4'd6;
    localparam logic [3:0] ST_WAIT   = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    function automatic logic [FC_W-1:0] index_of(input logic [PW-1:0] p,
                                                 input logic [FC_W-1:0] fc);
        logic [PW-1:0] end_p;
        end_p = {fc, {FRAC_BITS{1'b0}}};
        if (p >= end_p) begin
            return fc;
        end
        return p[PW-1:FRAC_BITS];
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                playing_reg, playing_next;
    logic [BW-1:0]       rem_reg, rem_next;
    logic [FC_W-1:0]     fc_reg;
    logic [CHAN_W-1:0]   sc_reg;
    logic [CHAN_W-1:0]   oc_reg;
    logic [STEP_W-1:0]   step_reg;
    sample_t             al_reg, bl_reg, ar_reg, br_reg, lres_reg;

    logic                m_valid_reg, m_valid_next;
    sample_t             m_left_reg, m_left_next;
    sample_t             m_right_reg, m_right_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [FC_W-1:0]     m_index_reg, m_index_next;
    logic                m_playing_reg, m_playing_next;
    logic                m_last_reg, m_last_next;

    logic [ACTION_W-1:0]    in_action;
    logic [LOAD_ADDR_W-1:0] in_addr;
    sample_t                in_sample;
    logic [COUNT_W-1:0]     in_count;

    logic                   accept;
    logic                   slot_free;
    logic [PW-1:0]          end_pos;
    logic [FC_W-1:0]        idx;
    logic [FC_W-1:0]        nxt;
    logic [CHAN_W-1:0]      stride;
    logic                   stereo_src;
    logic [RADDR_W-1:0]     a0, b0;
    logic [RADDR_W-1:0]     rd_addr;
    sample_t                rd_data;
    logic                   store_wr;

    logic [STEP_W-1:0]      step_eff;
    logic [SW-1:0]          step_wide;
    logic [SW-1:0]          step_sc;
    logic [PW:0]            pos_sum;
    logic [PW-1:0]          pos_adv;

    logic                   lerp_in_valid;
    sample_t                lerp_a, lerp_b;
    logic                   lerp_out_valid;
    sample_t                lerp_res;
    logic signed [SAMPLE_W:0] mono_sum;

    assign in_action = s_tuser;
    assign in_addr   = s_tdata[12:0];
    assign in_sample = s_tdata[28:13];
    assign in_count  = s_tdata[34:29];

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    assign end_pos    = {fc_reg, {FRAC_BITS{1'b0}}};
    assign idx        = pos_reg[PW-1:FRAC_BITS];
    assign nxt        = ((FC_W + 1)'(idx) + 1'b1 < (FC_W + 1)'(fc_reg)) ? idx + 1'b1 : idx;
    assign stride     = (sc_reg == '0) ? CHAN_W'(1) : sc_reg;
    assign stereo_src = (stride > CHAN_W'(1));
    assign a0         = RADDR_W'(idx) * RADDR_W'(stride);
    assign b0         = RADDR_W'(nxt) * RADDR_W'(stride);

    always_comb begin
        case (state_reg)
            ST_RD_B0: rd_addr = b0;
            ST_RD_A1: rd_addr = a0 + 1'b1;
            ST_RD_B1: rd_addr = b0 + 1'b1;
            default:  rd_addr = a0;
        endcase
    end

    assign store_wr = accept && (in_action == ACT_LOAD);

    lisp_store #(
        .STORE_WORDS(STORE_WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (in_addr),
        .wr_data (in_sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign lerp_in_valid = (state_reg == ST_LERP_L) || (state_reg == ST_LERP_R);
    assign lerp_a = (state_reg == ST_LERP_R && stereo_src) ? ar_reg : al_reg;
    assign lerp_b = (state_reg == ST_LERP_R)
                    ? (stereo_src ? br_reg : bl_reg) : bl_reg;

    lisp_lerp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_lerp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lerp_in_valid),
        .a         (lerp_a),
        .b         (lerp_b),
        .f         (pos_reg[FRAC_BITS-1:0]),
        .out_valid (lerp_out_valid),
        .result    (lerp_res)
    );

    assign step_eff  = (step_reg == '0) ? STEP_W'(65536) : step_reg;
    assign step_wide = {step_eff, {FRAC_BITS{1'b0}}};
    assign step_sc   = step_wide >> 16;
    assign pos_sum   = (PW + 1)'(pos_reg) + (PW + 1)'(step_sc);
    assign pos_adv   = pos_sum[PW] ? {PW{1'b1}} : pos_sum[PW-1:0];
    assign mono_sum  = (SAMPLE_W + 1)'(lres_reg) + (SAMPLE_W + 1)'(lerp_res);

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        playing_next   = playing_reg;
        rem_next       = rem_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_left_next    = m_left_reg;
        m_right_next   = m_right_reg;
        m_status_next  = m_status_reg;
        m_index_next   = m_index_reg;
        m_playing_next = m_playing_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next  = 1'b1;
                    m_left_next   = '0;
                    m_right_next  = '0;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                    case (in_action)
                        ACT_PLAY: begin
                            if (fc_reg == '0) begin
                                m_status_next = STAT_NO_STREAM;
                            end else begin
                                playing_next = 1'b1;
                            end
                        end
                        ACT_STOP: begin
                            playing_next = 1'b0;
                        end
                        ACT_REWIND: begin
                            pos_next = '0;
                        end
                        ACT_PRODUCE: begin
                            if (fc_reg == '0) begin
                                m_status_next = STAT_NO_STREAM;
                            end else if (!playing_reg) begin
                                m_status_next = STAT_NOT_PLAYING;
                            end else if (in_count == '0) begin
                                m_status_next = STAT_OK;
                            end else if (pos_reg >= end_pos) begin
                                playing_next  = 1'b0;
                                m_status_next = STAT_NOT_PLAYING;
                            end else begin
                                m_valid_next = m_valid_reg && !m_tready;
                                state_next   = ST_RD_A0;
                                if (32'(in_count) > MAX_BURST) begin
                                    rem_next = BW'(MAX_BURST);
                                end else begin
                                    rem_next = BW'(in_count);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_index_next   = index_of(pos_next, fc_reg);
                    m_playing_next = playing_next;
                end
            end
            ST_RD_A0:  state_next = ST_RD_B0;
            ST_RD_B0:  state_next = ST_RD_A1;
            ST_RD_A1:  state_next = ST_RD_B1;
            ST_RD_B1:  state_next = ST_LERP_L;
            ST_LERP_L: state_next = ST_LERP_R;
            ST_LERP_R: state_next = ST_WAIT;
            ST_WAIT: begin
                if (lerp_out_valid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    pos_next       = pos_adv;
                    playing_next   = (pos_adv < end_pos);
                    rem_next       = rem_reg - 1'b1;
                    m_valid_next   = 1'b1;
                    m_status_next  = STAT_OK;
                    m_index_next   = index_of(pos_adv, fc_reg);
                    m_playing_next = playing_next;
                    m_last_next    = (rem_reg == BW'(1)) || !playing_next;
                    if (oc_reg == CHAN_W'(1)) begin
                        m_left_next  = mono_sum[SAMPLE_W:1];
                        m_right_next = '0;
                    end else begin
                        m_left_next  = lres_reg;
                        m_right_next = lerp_res;
                    end
                    state_next = m_last_next ? ST_IDLE : ST_RD_A0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            playing_reg <= 1'b0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
            fc_reg      <= '0;
            sc_reg      <= CHAN_W'(2);
            oc_reg      <= CHAN_W'(2);
            step_reg    <= STEP_W'(65536);
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            playing_reg <= playing_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_FRAME_COUNT:     fc_reg   <= cfg_wdata[FC_W-1:0];
                    CFG_SOURCE_CHANNELS: sc_reg   <= cfg_wdata[CHAN_W-1:0];
                    CFG_OUTPUT_CHANNELS: oc_reg   <= cfg_wdata[CHAN_W-1:0];
                    CFG_STEP:            step_reg <= cfg_wdata[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        case (state_reg)
            ST_RD_B0:  al_reg <= rd_data;
            ST_RD_A1:  bl_reg <= rd_data;
            ST_RD_B1:  ar_reg <= rd_data;
            ST_LERP_L: br_reg <= rd_data;
            ST_WAIT:   lres_reg <= lerp_res;
            default: begin
            end
        endcase
        m_left_reg    <= m_left_next;
        m_right_reg   <= m_right_next;
        m_status_reg  <= m_status_next;
        m_index_reg   <= m_index_next;
        m_playing_reg <= m_playing_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_playing_reg, m_index_reg, m_right_reg, m_left_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
